// ----- rtl/bli_pkg.sv -----
// ----------------------------------------------------------------------------
// bli_pkg
// Shared widths, types and codes for the blend interpolator pipeline.
// ----------------------------------------------------------------------------
package bli_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int RATE_FRAC_BITS = 16;
    localparam int STEP_BITS      = 16;
    localparam int DUR_BITS       = 16;
    localparam int MODE_BITS      = 2;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int N_TERMS        = 4;

    // rate is Q0.F plus one integer bit so that exactly one fits
    localparam int RATE_BITS = RATE_FRAC_BITS + 1;
    // weights reach about +/-3 in Q(F)
    localparam int WGT_BITS  = RATE_FRAC_BITS + 4;
    localparam int PROD_BITS = VALUE_BITS + WGT_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int SHR_BITS  = SUM_BITS - RATE_FRAC_BITS;

    // divider: quotient bits resolved per stage
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = (RATE_FRAC_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int CURVE_STAGES = 3;
    localparam int MAC_STAGES   = 3;
    localparam int PIPE_STAGES  = DIV_STAGES + CURVE_STAGES + MAC_STAGES;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [STEP_BITS-1:0]         t_step;
    typedef logic [DUR_BITS-1:0]          t_dur;
    typedef logic [MODE_BITS-1:0]         t_mode;
    typedef logic [CFG_IDX_BITS-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]     t_cfg_data;
    typedef logic [RATE_BITS-1:0]         t_rate;
    typedef logic [RATE_FRAC_BITS-1:0]    t_quot;
    typedef logic signed [WGT_BITS-1:0]   t_weight;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef logic signed [SHR_BITS-1:0]   t_shr;

    typedef t_weight t_weights [N_TERMS];

    typedef struct packed {
        t_value start_value;
        t_value end_value;
        t_value start_tangent;
        t_value end_tangent;
    } t_terms;

    localparam t_mode MODE_LINEAR  = t_mode'(0);
    localparam t_mode MODE_SMOOTH  = t_mode'(1);
    localparam t_mode MODE_HERMITE = t_mode'(2);

    localparam t_cfg_idx CFG_BLEND_MODE = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_DURATION   = t_cfg_idx'(1);

    localparam t_rate RATE_ONE = {1'b1, {RATE_FRAC_BITS{1'b0}}};

endpackage

// ----- rtl/bli_in_if.sv -----
// ----------------------------------------------------------------------------
// bli_in_if
// Request channel: step count, end points and tangents of one component.
// ----------------------------------------------------------------------------
interface bli_in_if;
    import bli_pkg::*;

    logic   valid;
    logic   ready;
    t_step  step;
    t_value start_value;
    t_value end_value;
    t_value start_tangent;
    t_value end_tangent;

    modport source (
        output valid, step, start_value, end_value, start_tangent, end_tangent,
        input  ready
    );

    modport sink (
        input  valid, step, start_value, end_value, start_tangent, end_tangent,
        output ready
    );

endinterface

// ----- rtl/bli_out_if.sv -----
// ----------------------------------------------------------------------------
// bli_out_if
// Result channel: one blended component per request.
// ----------------------------------------------------------------------------
interface bli_out_if;
    import bli_pkg::*;

    logic   valid;
    logic   ready;
    t_value blended_value;

    modport source (
        output valid, blended_value,
        input  ready
    );

    modport sink (
        input  valid, blended_value,
        output ready
    );

endinterface

// ----- rtl/bli_divider.sv -----
// ----------------------------------------------------------------------------
// bli_divider
// Pipelined restoring divider: (step << F) / duration, DIV_BITS quotient bits
// per stage. Carries the saturate flag alongside.
// ----------------------------------------------------------------------------
module bli_divider (
    input  logic                               i_clk,
    input  logic [bli_pkg::DIV_STAGES-1:0]     i_en,
    input  bli_pkg::t_step                     i_step,
    input  logic                               i_sat,
    input  bli_pkg::t_dur                      i_dur,
    output bli_pkg::t_quot                     o_quot,
    output logic                               o_sat
);
    import bli_pkg::*;

    // last stage keeps no remainder
    t_dur  r_rem  [DIV_STAGES-1];
    t_quot r_quot [DIV_STAGES];
    logic  r_sat  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        t_dur  rem_in;
        t_quot quot_in;
        logic  sat_in;
        t_dur  n_rem;
        t_quot n_quot;

        if (k == 0) begin : g_first
            assign rem_in  = i_step;
            assign quot_in = '0;
            assign sat_in  = i_sat;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign quot_in = r_quot[k-1];
            assign sat_in  = r_sat[k-1];
        end

        always_comb begin
            logic [DUR_BITS:0] trial;
            trial  = '0;
            n_rem  = rem_in;
            n_quot = quot_in;
            for (int j = 0; j < DIV_BITS; j++) begin
                if (k * DIV_BITS + j < RATE_FRAC_BITS) begin
                    trial = {n_rem, 1'b0};
                    if (trial >= {1'b0, i_dur}) begin
                        n_rem  = DUR_BITS'(trial - {1'b0, i_dur});
                        n_quot = {n_quot[RATE_FRAC_BITS-2:0], 1'b1};
                    end else begin
                        n_rem  = trial[DUR_BITS-1:0];
                        n_quot = {n_quot[RATE_FRAC_BITS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_quot[k] <= n_quot;
                r_sat[k]  <= sat_in;
            end
        end

        if (k < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];
    assign o_sat  = r_sat[DIV_STAGES-1];

endmodule

// ----- rtl/bli_curve.sv -----
// ----------------------------------------------------------------------------
// bli_curve
// Rate to basis weights: t^2, then t^3, then the mode's weight set.
// ----------------------------------------------------------------------------
module bli_curve (
    input  logic                                i_clk,
    input  logic [bli_pkg::CURVE_STAGES-1:0]    i_en,
    input  logic                                i_sat,
    input  bli_pkg::t_quot                      i_quot,
    input  bli_pkg::t_mode                      i_mode,
    output bli_pkg::t_weights                   o_weights
);
    import bli_pkg::*;

    t_rate    rate;
    logic [2*RATE_BITS-1:0] sq;
    logic [2*RATE_BITS-1:0] cube;
    t_rate    r_t_a;
    t_rate    r_t2_a;
    t_rate    r_t_b;
    t_rate    r_t2_b;
    t_rate    r_t3_b;
    t_weight  wt;
    t_weight  wt2;
    t_weight  wt3;
    t_weight  one;
    t_weight  s;
    t_weights n_w;
    t_weights r_w;

    // stage A: rate and square
    assign rate = i_sat ? RATE_ONE : {1'b0, i_quot};
    assign sq   = (2*RATE_BITS)'(rate) * (2*RATE_BITS)'(rate);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t_a  <= rate;
            r_t2_a <= sq[RATE_FRAC_BITS +: RATE_BITS];
        end
    end

    // stage B: cube
    assign cube = (2*RATE_BITS)'(r_t2_a) * (2*RATE_BITS)'(r_t_a);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t_b  <= r_t_a;
            r_t2_b <= r_t2_a;
            r_t3_b <= cube[RATE_FRAC_BITS +: RATE_BITS];
        end
    end

    // stage C: weights
    assign wt  = t_weight'({{(WGT_BITS-RATE_BITS){1'b0}}, r_t_b});
    assign wt2 = t_weight'({{(WGT_BITS-RATE_BITS){1'b0}}, r_t2_b});
    assign wt3 = t_weight'({{(WGT_BITS-RATE_BITS){1'b0}}, r_t3_b});
    assign one = t_weight'({{(WGT_BITS-RATE_BITS){1'b0}}, RATE_ONE});
    assign s   = (wt2 <<< 1) + wt2 - (wt3 <<< 1);

    always_comb begin
        n_w[2] = '0;
        n_w[3] = '0;
        case (i_mode)
            MODE_SMOOTH: begin
                n_w[0] = one - s;
                n_w[1] = s;
            end
            MODE_HERMITE: begin
                n_w[0] = (wt3 <<< 1) - wt2 - (wt2 <<< 1) + one;
                n_w[1] = s;
                n_w[2] = wt3 - (wt2 <<< 1) + wt;
                n_w[3] = wt3 - wt2;
            end
            default: begin
                n_w[0] = one - wt;
                n_w[1] = wt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_w <= n_w;
        end
    end

    assign o_weights = r_w;

endmodule

// ----- rtl/bli_mac.sv -----
// ----------------------------------------------------------------------------
// bli_mac
// Weighted sum of the four terms: products, rounded sum, saturation.
// ----------------------------------------------------------------------------
module bli_mac (
    input  logic                              i_clk,
    input  logic [bli_pkg::MAC_STAGES-1:0]    i_en,
    input  bli_pkg::t_terms                   i_terms,
    input  bli_pkg::t_weights                 i_weights,
    output bli_pkg::t_value                   o_value
);
    import bli_pkg::*;

    localparam t_sum HALF = t_sum'(1) <<< (RATE_FRAC_BITS - 1);

    t_value vals [N_TERMS];
    t_prod  r_prod [N_TERMS];
    t_sum   sum;
    t_shr   r_shr;
    logic   ovf;
    t_value n_out;
    t_value r_out;

    assign vals[0] = i_terms.start_value;
    assign vals[1] = i_terms.end_value;
    assign vals[2] = i_terms.start_tangent;
    assign vals[3] = i_terms.end_tangent;

    // stage P: four independent products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < N_TERMS; i++) begin
                r_prod[i] <= t_prod'(vals[i]) * t_prod'(i_weights[i]);
            end
        end
    end

    // stage S: exact sum, round half up, drop fraction
    assign sum = t_sum'(r_prod[0]) + t_sum'(r_prod[1]) + t_sum'(r_prod[2])
               + t_sum'(r_prod[3]) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_shr <= t_shr'(sum >>> RATE_FRAC_BITS);
        end
    end

    // stage O: clamp to the value range
    assign ovf = (r_shr[SHR_BITS-1:VALUE_BITS-1] != '0)
              && (r_shr[SHR_BITS-1:VALUE_BITS-1] != '1);

    always_comb begin
        if (!ovf) begin
            n_out = r_shr[VALUE_BITS-1:0];
        end else if (r_shr[SHR_BITS-1]) begin
            n_out = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_out <= n_out;
        end
    end

    assign o_value = r_out;

endmodule

// ----- rtl/blend_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// blend_interpolator_unit
// Per-component blend of two Q16.16 values: linear, smoothstep or cubic
// Hermite, at a rate of step / duration.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_req     in   valid / ready      step, start_value, end_value,
//                                    start_tangent, end_tangent
//  o_rsp     out  valid / ready      blended_value
//  i_cfg_*   in   write enable only  idx 0 blend_mode, idx 1 duration
//
//  One request per cycle sustained while o_rsp.ready holds. Stages in order:
//  DIV_STAGES divider stages at two quotient bits each, then square, cube,
//  weights, products, rounded sum and clamp.
//  Synchronous active-low reset clears the stage valid bits and loads
//  blend_mode = linear, duration = 1.
//  Stalls: each stage holds while full and its successor is blocked; empty
//  stages keep taking requests, so bubbles close up behind a stalled output.
//
module blend_interpolator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  bli_pkg::t_cfg_idx     i_cfg_idx,
    input  bli_pkg::t_cfg_data    i_cfg_data,
    bli_in_if.sink                i_req,
    bli_out_if.source             o_rsp
);
    import bli_pkg::*;

    localparam int CARRY_STAGES = DIV_STAGES + CURVE_STAGES;

    // configuration
    t_mode r_mode;
    t_dur  r_dur;

    // flow control
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] stage_en;

    // end points and tangents ride alongside divider and curve stages
    t_terms   r_terms [CARRY_STAGES];
    t_terms   req_terms;

    logic     sat;
    t_quot    quot;
    logic     quot_sat;
    t_weights weights;
    t_value   blended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_dur  <= t_dur'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLEND_MODE: r_mode <= i_cfg_data[MODE_BITS-1:0];
                CFG_DURATION:   r_dur  <= i_cfg_data[DUR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage loads when empty or when its content moves on
    always_comb begin
        stage_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || o_rsp.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = stage_en[0];

    assign req_terms.start_value   = i_req.start_value;
    assign req_terms.end_value     = i_req.end_value;
    assign req_terms.start_tangent = i_req.start_tangent;
    assign req_terms.end_tangent   = i_req.end_tangent;

    for (genvar k = 0; k < CARRY_STAGES; k++) begin : g_carry
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (stage_en[k]) begin
                    r_terms[k] <= req_terms;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (stage_en[k]) begin
                    r_terms[k] <= r_terms[k-1];
                end
            end
        end
    end

    // rate is exactly one at or past the end, and for a zero duration
    assign sat = (r_dur == '0) || (i_req.step >= r_dur);

    bli_divider u_div (
        .i_clk  (i_clk),
        .i_en   (stage_en[DIV_STAGES-1:0]),
        .i_step (i_req.step),
        .i_sat  (sat),
        .i_dur  (r_dur),
        .o_quot (quot),
        .o_sat  (quot_sat)
    );

    bli_curve u_curve (
        .i_clk     (i_clk),
        .i_en      (stage_en[DIV_STAGES +: CURVE_STAGES]),
        .i_sat     (quot_sat),
        .i_quot    (quot),
        .i_mode    (r_mode),
        .o_weights (weights)
    );

    bli_mac u_mac (
        .i_clk     (i_clk),
        .i_en      (stage_en[CARRY_STAGES +: MAC_STAGES]),
        .i_terms   (r_terms[CARRY_STAGES-1]),
        .i_weights (weights),
        .o_value   (blended)
    );

    assign o_rsp.valid         = r_vld[PIPE_STAGES-1];
    assign o_rsp.blended_value = blended;

endmodule
